// File: rtl/core/kbq_pkg.sv
// ============================================================================
// kbq_pkg - shared types and constants for the key state / event queue
// Function codes, fixed scan codes, controller states and the command and
// status bundles between controller and datapath.
// ============================================================================
package kbq_pkg;

    localparam int KEY_COUNT           = 128;
    localparam int KEY_W               = $clog2(KEY_COUNT);
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [7:0]       BREAK_SCAN     = 8'd46;
    localparam logic [7:0]       RELEASE_ALL_LO = 8'd128;
    localparam logic [7:0]       RELEASE_ALL_HI = 8'd129;
    localparam logic [KEY_W-1:0] EXIT_KEY_RESET = KEY_W'(45);

    // bit positions in the modifier byte
    localparam int CTRL_BIT = 2;
    localparam int ALT_BIT  = 3;

    typedef enum logic [2:0] {
        FN_RAW   = 3'd0,
        FN_PUSH  = 3'd1,
        FN_READ  = 3'd2,
        FN_FLUSH = 3'd3,
        FN_QUERY = 3'd4
    } kbq_func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_POP
    } kbq_state_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] scan_byte;
        logic [7:0] mods;
    } kbq_slot_t;

    typedef struct packed {
        logic capture;
        logic exec_op;
        logic push_break;
        logic mem_rd;
        logic pop_load;
        logic empty_load;
    } kbq_cmd_t;

    typedef struct packed {
        logic func_is_read;
        logic break_pending;
        logic queue_nonempty;
        logic out_free;
    } kbq_status_t;

endpackage

// File: rtl/core/kbq_ctrl.sv
// ============================================================================
// kbq_ctrl - sequencer for the key state / event queue
// Steps one word at a time through execute, break injection, slot read and
// result load; drives the datapath through a command bundle.
// ============================================================================
module kbq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  kbq_pkg::kbq_status_t status,
    output kbq_pkg::kbq_cmd_t    cmd
);

    kbq_pkg::kbq_state_t state_reg;
    kbq_pkg::kbq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kbq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            kbq_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = kbq_pkg::ST_EXEC;
                end
            end
            kbq_pkg::ST_EXEC:
            begin
                if (status.func_is_read)
                begin
                    // pending Ctrl-C goes into the queue ahead of the pop
                    cmd.push_break = status.break_pending;
                    state_next     = kbq_pkg::ST_READ;
                end
                else if (status.out_free)
                begin
                    cmd.exec_op = 1'b1;
                    state_next  = kbq_pkg::ST_IDLE;
                end
            end
            kbq_pkg::ST_READ:
            begin
                if (status.queue_nonempty)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = kbq_pkg::ST_POP;
                end
                else if (status.out_free)
                begin
                    cmd.empty_load = 1'b1;
                    state_next     = kbq_pkg::ST_IDLE;
                end
            end
            kbq_pkg::ST_POP:
            begin
                if (status.out_free)
                begin
                    cmd.pop_load = 1'b1;
                    state_next   = kbq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kbq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/kbq_dp.sv
// ============================================================================
// kbq_dp - datapath for the key state / event queue
// Key-down flags, event slot memory with ring pointers, break and exit
// flags, the exit key register and the output register.
// ============================================================================
module kbq_dp
#(
    parameter int QUEUE_DEPTH = kbq_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  kbq_pkg::kbq_cmd_t           cmd,
    output kbq_pkg::kbq_status_t        status,
    input  logic                        cfg_wr_en,
    input  logic [kbq_pkg::KEY_W-1:0]   cfg_wr_data,
    input  logic [2:0]                  func,
    input  logic [7:0]                  raw_code,
    input  logic [7:0]                  char_code,
    input  logic [7:0]                  modifier_bits,
    input  logic [kbq_pkg::KEY_W-1:0]   key_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  event_char,
    output logic [7:0]                  event_scan,
    output logic [7:0]                  event_modifiers,
    output logic                        exit_flag,
    output logic                        key_down,
    output logic                        queue_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    // captured word
    logic [2:0]                func_reg;
    logic [7:0]                code_reg;
    logic [7:0]                char_reg;
    logic [7:0]                mods_reg;
    logic [kbq_pkg::KEY_W-1:0] key_reg;

    logic [kbq_pkg::KEY_COUNT-1:0] flags_reg;
    logic [kbq_pkg::KEY_COUNT-1:0] flags_next;
    logic [PTR_W-1:0]              rp_reg;
    logic [PTR_W-1:0]              rp_next;
    logic [PTR_W-1:0]              wp_reg;
    logic [PTR_W-1:0]              wp_next;
    logic [PTR_W-1:0]              wp_inc;
    logic                          break_reg;
    logic                          break_next;
    logic                          exit_reg;
    logic                          exit_next;
    logic [kbq_pkg::KEY_W-1:0]     exit_key_reg;

    kbq_pkg::kbq_slot_t slots_mem [QUEUE_DEPTH];
    kbq_pkg::kbq_slot_t rd_data_reg;
    kbq_pkg::kbq_slot_t push_word;
    logic               push_en;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic [7:0] out_scan_reg;
    logic [7:0] out_mods_reg;
    logic       out_exit_reg;
    logic       out_down_reg;
    logic       out_empty_reg;
    logic [7:0] res_char;
    logic [7:0] res_scan;
    logic [7:0] res_mods;
    logic       res_down;
    logic       out_load;
    logic       out_free;

    assign out_load = cmd.exec_op | cmd.pop_load | cmd.empty_load;
    assign out_free = ~out_valid_reg | ~out_stall;
    assign wp_inc   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;

    assign status.func_is_read   = (func_reg == kbq_pkg::FN_READ);
    assign status.break_pending  = break_reg;
    assign status.queue_nonempty = (rp_reg != wp_reg);
    assign status.out_free       = out_free;

    always_comb
    begin
        flags_next = flags_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        break_next = break_reg;
        exit_next  = exit_reg;
        push_en    = 1'b0;
        push_word  = '{char_code: char_reg, scan_byte: code_reg, mods: mods_reg};
        res_char   = 8'd0;
        res_scan   = 8'd0;
        res_mods   = 8'd0;
        res_down   = 1'b0;

        if (cmd.push_break)
        begin
            push_en    = 1'b1;
            push_word  = '{char_code: 8'd0, scan_byte: kbq_pkg::BREAK_SCAN, mods: mods_reg};
            break_next = 1'b0;
        end

        if (cmd.exec_op)
        begin
            unique case (func_reg)
                kbq_pkg::FN_RAW:
                begin
                    if (mods_reg[kbq_pkg::CTRL_BIT] && code_reg == kbq_pkg::BREAK_SCAN)
                    begin
                        flags_next[kbq_pkg::BREAK_SCAN[kbq_pkg::KEY_W-1:0]] = 1'b1;
                        break_next = 1'b1;
                    end
                    else if (!code_reg[7])
                    begin
                        flags_next[code_reg[kbq_pkg::KEY_W-1:0]] = 1'b1;
                    end
                    else if (code_reg != kbq_pkg::RELEASE_ALL_LO &&
                             code_reg != kbq_pkg::RELEASE_ALL_HI)
                    begin
                        // break code: key number is the low seven bits
                        flags_next[code_reg[kbq_pkg::KEY_W-1:0]] = 1'b0;
                    end
                    else
                    begin
                        flags_next = '0;
                    end
                end
                kbq_pkg::FN_PUSH:
                begin
                    push_en = 1'b1;
                end
                kbq_pkg::FN_FLUSH:
                begin
                    rp_next  = '0;
                    wp_next  = '0;
                    res_mods = mods_reg;
                end
                kbq_pkg::FN_QUERY:
                begin
                    res_down = flags_reg[key_reg];
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.empty_load)
        begin
            res_mods = mods_reg;
        end

        if (cmd.pop_load)
        begin
            res_char  = rd_data_reg.char_code;
            res_scan  = rd_data_reg.scan_byte;
            res_mods  = rd_data_reg.mods;
            exit_next = rd_data_reg.mods[kbq_pkg::ALT_BIT] &&
                        (rd_data_reg.scan_byte == {1'b0, exit_key_reg});
            rp_next   = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
        end

        // full queue: write pointer stays, so the pushed word lands outside the pointers and is dropped
        if (push_en)
        begin
            wp_next = (wp_inc == rp_reg) ? wp_reg : wp_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            break_reg     <= 1'b0;
            exit_reg      <= 1'b0;
            exit_key_reg  <= kbq_pkg::EXIT_KEY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg <= flags_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            break_reg <= break_next;
            exit_reg  <= exit_next;
            if (cfg_wr_en)
            begin
                exit_key_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            code_reg <= raw_code;
            char_reg <= char_code;
            mods_reg <= modifier_bits;
            key_reg  <= key_index;
        end
        if (out_load)
        begin
            out_char_reg  <= res_char;
            out_scan_reg  <= res_scan;
            out_mods_reg  <= res_mods;
            out_exit_reg  <= exit_next;
            out_down_reg  <= res_down;
            out_empty_reg <= (rp_next == wp_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            slots_mem[wp_reg] <= push_word;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= slots_mem[rp_reg];
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_char      = out_char_reg;
    assign event_scan      = out_scan_reg;
    assign event_modifiers = out_mods_reg;
    assign exit_flag       = out_exit_reg;
    assign key_down        = out_down_reg;
    assign queue_empty     = out_empty_reg;

endmodule

// File: rtl/core/keyboard_key_state_and_event_queue.sv
// ============================================================================
// keyboard_key_state_and_event_queue - key-down table and key event queue
// Top level: sequencer plus datapath, exit key register on a write port.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one operation word: func,
//   raw_code, char_code, modifier_bits, key_index. Every word yields exactly
//   one result word on the output channel (out_valid / out_stall).
//   The block works on one word at a time; in_stall is high from the cycle
//   after acceptance until the result is loaded into the output register.
//   From acceptance to the output register: raw scancode, push, flush,
//   query and unused codes load from the execute state; a read passes the
//   execute state (optional Ctrl-C injection) and the read state, which
//   checks the queue and loads an empty result, while a pop goes on to load
//   from the pop state after the registered read port of the slot memory.
//   The next word is accepted only once the sequencer is back in idle.
//   A result held under out_stall does not block acceptance of the next
//   word; that word waits in the sequencer only when its own result is due.
//   Reset clears all key flags, both queue pointers, the pending break and
//   exit flags, and sets the exit key to scan code 45; no sweep is needed.
//   cfg_wr_en writes the exit key scan code; write only while idle.
// ============================================================================
module keyboard_key_state_and_event_queue
#(
    parameter int QUEUE_DEPTH = kbq_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [kbq_pkg::KEY_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                func,
    input  logic [7:0]                raw_code,
    input  logic [7:0]                char_code,
    input  logic [7:0]                modifier_bits,
    input  logic [kbq_pkg::KEY_W-1:0] key_index,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                event_char,
    output logic [7:0]                event_scan,
    output logic [7:0]                event_modifiers,
    output logic                      exit_flag,
    output logic                      key_down,
    output logic                      queue_empty
);

    kbq_pkg::kbq_cmd_t    cmd;
    kbq_pkg::kbq_status_t status;

    kbq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kbq_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .func            (func),
        .raw_code        (raw_code),
        .char_code       (char_code),
        .modifier_bits   (modifier_bits),
        .key_index       (key_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_char      (event_char),
        .event_scan      (event_scan),
        .event_modifiers (event_modifiers),
        .exit_flag       (exit_flag),
        .key_down        (key_down),
        .queue_empty     (queue_empty)
    );

    // one word in flight: an accepted word blocks the input next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("word accepted while another is in flight");

    // a pop only reads a slot between the pointers
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd |-> status.queue_nonempty)
        else $error("slot read on empty queue");

    // results only go into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec_op || cmd.pop_load || cmd.empty_load) |-> status.out_free)
        else $error("result overwrote a pending output word");

    // break injection only with a pending Ctrl-C, and it clears it
    a_break_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_break |-> status.break_pending ##1 !status.break_pending)
        else $error("break injection out of order");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec_op, cmd.push_break, cmd.mem_rd, cmd.pop_load,
                  cmd.empty_load}))
        else $error("conflicting datapath commands");

endmodule
